// File: hdl/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg
// Shared widths, register codes and types of the block average pixelate unit.
// ----------------------------------------------------------------------------
package bap_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_BLOCK    = 64;
    localparam int MIN_BLOCK    = 4;
    localparam int HEIGHT_LIMIT = 2048;

    localparam int SUM_DEPTH = MAX_WIDTH / MIN_BLOCK;
    localparam int COL_W     = $clog2(SUM_DEPTH);
    localparam int BLK_LOG   = $clog2(MAX_BLOCK);

    localparam int PIX_W  = 8;
    localparam int SEG_W  = PIX_W + BLK_LOG;
    localparam int SUM_W  = PIX_W + 2 * BLK_LOG;
    localparam int AREA_W = 2 * BLK_LOG + 1;
    localparam int BS_W   = BLK_LOG + 1;
    localparam int OFS_W  = BLK_LOG;
    localparam int DIM_W  = $clog2(HEIGHT_LIMIT) + 1;
    localparam int POS_W  = $clog2(MAX_WIDTH);
    localparam int CFG_W  = 12;
    localparam int CFG_IDX_W = 2;

    localparam int Q_STEPS = PIX_W;
    localparam int STEP_W  = $clog2(Q_STEPS);

    localparam int JOB_DEPTH = 4;
    localparam int JOB_AW    = $clog2(JOB_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [BS_W-1:0]  BS_RESET = BS_W'(20);
    localparam logic [DIM_W-1:0] W_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] H_RESET  = DIM_W'(480);
    localparam logic [BS_W-1:0]  BS_MIN   = BS_W'(MIN_BLOCK);
    localparam logic [BS_W-1:0]  BS_MAX   = BS_W'(MAX_BLOCK);
    localparam logic [DIM_W-1:0] W_MAX    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_MAX    = DIM_W'(HEIGHT_LIMIT);

    typedef struct packed {
        logic [BS_W-1:0]  block_size;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cfg;

    // one horizontal run of a block inside one line
    typedef struct packed {
        logic [COL_W-1:0]       bcol;
        logic [COL_W-1:0]       brow;
        logic                   first;
        logic                   last;
        logic                   done;
        logic [2:0][SEG_W-1:0]  seg;
    } t_job;

    typedef struct packed {
        logic [2:0][PIX_W-1:0] avg;
        logic [COL_W-1:0]      bcol;
        logic [COL_W-1:0]      brow;
        logic                  done;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_OUT
    } t_back_state;

endpackage

// File: hdl/bap_ram.sv
// ----------------------------------------------------------------------------
// bap_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/bap_fifo.sv
// ----------------------------------------------------------------------------
// bap_fifo
// Short job queue between the raster front end and the accumulate back end.
// ----------------------------------------------------------------------------
module bap_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bap_pkg::t_job i_job,
    input  logic          i_pop,
    output bap_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);
    import bap_pkg::*;

    t_job              r_mem [JOB_DEPTH];
    logic [JOB_AW-1:0] r_wr;
    logic [JOB_AW-1:0] r_rd;
    logic [JOB_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (JOB_AW+1)'(JOB_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (JOB_AW+1)'(JOB_DEPTH)) else $error("job count out of range");

endmodule

// File: hdl/bap_front.sv
// ----------------------------------------------------------------------------
// bap_front
// Tracks the raster position, sums each block run along a line and queues it.
// ----------------------------------------------------------------------------
module bap_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bap_pkg::t_cfg              i_cfg,
    input  logic                       i_restart,
    input  logic                       i_accept,
    input  logic [bap_pkg::PIX_W-1:0]  i_red,
    input  logic [bap_pkg::PIX_W-1:0]  i_green,
    input  logic [bap_pkg::PIX_W-1:0]  i_blue,
    input  logic                       i_frame_start,
    output logic                       o_job_push,
    output bap_pkg::t_job              o_job
);
    import bap_pkg::*;

    localparam int EXT_W = DIM_W + 1;

    logic [POS_W-1:0] r_px, r_py, r_xs, r_ys;
    logic [OFS_W-1:0] r_ox, r_oy;
    logic [COL_W-1:0] r_bcol, r_brow;
    logic [2:0][SEG_W-1:0] r_acc;

    logic [POS_W-1:0] e_px, e_py, e_xs, e_ys;
    logic [OFS_W-1:0] e_ox, e_oy;
    logic [COL_W-1:0] e_bcol, e_brow;

    logic [POS_W-1:0] n_px, n_py, n_xs, n_ys;
    logic [OFS_W-1:0] n_ox, n_oy;
    logic [COL_W-1:0] n_bcol, n_brow;
    logic [2:0][SEG_W-1:0] n_acc;

    logic [EXT_W-1:0] x_end, y_end, bs_e, w_e, h_e;
    logic             whole_x, whole_y, last_x, last_y, seg_last;
    logic [BS_W-1:0]  ox1, oy1;
    logic [DIM_W-1:0] px1, py1;
    logic [2:0][PIX_W-1:0] pix;

    always_comb begin
        pix    = {i_blue, i_green, i_red};
        e_px   = i_frame_start ? '0 : r_px;
        e_py   = i_frame_start ? '0 : r_py;
        e_xs   = i_frame_start ? '0 : r_xs;
        e_ys   = i_frame_start ? '0 : r_ys;
        e_ox   = i_frame_start ? '0 : r_ox;
        e_oy   = i_frame_start ? '0 : r_oy;
        e_bcol = i_frame_start ? '0 : r_bcol;
        e_brow = i_frame_start ? '0 : r_brow;

        bs_e  = EXT_W'(i_cfg.block_size);
        w_e   = EXT_W'(i_cfg.width);
        h_e   = EXT_W'(i_cfg.height);
        x_end = EXT_W'(e_xs) + bs_e;
        y_end = EXT_W'(e_ys) + bs_e;
        whole_x = (x_end <= w_e);
        whole_y = (y_end <= h_e);
        last_x  = ((x_end + bs_e) > w_e);
        last_y  = ((y_end + bs_e) > h_e);

        ox1 = BS_W'(e_ox) + 1'b1;
        oy1 = BS_W'(e_oy) + 1'b1;
        seg_last = (ox1 == i_cfg.block_size);

        for (int c = 0; c < 3; c++) begin
            n_acc[c] = (e_ox == '0) ? SEG_W'(pix[c]) : r_acc[c] + SEG_W'(pix[c]);
        end

        o_job_push = i_accept && whole_x && whole_y && seg_last;
        o_job.bcol  = e_bcol;
        o_job.brow  = e_brow;
        o_job.first = (e_oy == '0);
        o_job.last  = (oy1 == i_cfg.block_size);
        o_job.done  = last_x && last_y;
        o_job.seg   = n_acc;

        // advance the position
        n_px   = e_px;
        n_py   = e_py;
        n_xs   = e_xs;
        n_ys   = e_ys;
        n_ox   = ox1[OFS_W-1:0];
        n_oy   = e_oy;
        n_bcol = e_bcol;
        n_brow = e_brow;
        if (ox1 >= i_cfg.block_size) begin
            n_ox   = '0;
            n_xs   = POS_W'(x_end);
            n_bcol = e_bcol + 1'b1;
        end
        px1 = DIM_W'(e_px) + 1'b1;
        py1 = DIM_W'(e_py) + 1'b1;
        n_px = px1[POS_W-1:0];
        if (px1 >= i_cfg.width) begin
            n_px   = '0;
            n_ox   = '0;
            n_xs   = '0;
            n_bcol = '0;
            n_oy   = oy1[OFS_W-1:0];
            n_py   = py1[POS_W-1:0];
            if (oy1 >= i_cfg.block_size) begin
                n_oy   = '0;
                n_ys   = POS_W'(y_end);
                n_brow = e_brow + 1'b1;
            end
            if (py1 >= i_cfg.height) begin
                n_py   = '0;
                n_oy   = '0;
                n_ys   = '0;
                n_brow = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_px   <= '0;
            r_py   <= '0;
            r_xs   <= '0;
            r_ys   <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_bcol <= '0;
            r_brow <= '0;
        end else if (i_accept) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_xs   <= n_xs;
            r_ys   <= n_ys;
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_bcol <= n_bcol;
            r_brow <= n_brow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_acc <= n_acc;
        end
    end

endmodule

// File: hdl/bap_back.sv
// ----------------------------------------------------------------------------
// bap_back
// Adds block runs into the column sums and divides finished blocks by area.
// ----------------------------------------------------------------------------
module bap_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bap_pkg::AREA_W-1:0]         i_area,
    input  bap_pkg::t_job                      i_job_head,
    input  logic                               i_job_empty,
    output logic                               o_job_pop,
    output logic                               o_ram_we,
    output logic [bap_pkg::COL_W-1:0]          o_ram_waddr,
    output logic [3*bap_pkg::SUM_W-1:0]        o_ram_wdata,
    output logic [bap_pkg::COL_W-1:0]          o_ram_raddr,
    input  logic [3*bap_pkg::SUM_W-1:0]        i_ram_rdata,
    output logic                               o_res_valid,
    output bap_pkg::t_result                   o_res,
    input  logic                               i_res_pop
);
    import bap_pkg::*;

    localparam int DV_W = SUM_W + 1;

    t_back_state          r_state, n_state;
    t_job                 r_job;
    logic [2:0][SUM_W-1:0] r_rem;
    logic [2:0][PIX_W-1:0] r_q;
    logic [STEP_W-1:0]    r_step;
    logic                 r_out_valid;
    t_result              r_out;

    logic [2:0][SUM_W-1:0] sum;
    logic [DV_W-1:0]       dvs;
    logic [2:0]            fits;
    logic                  out_load;

    always_comb begin
        dvs = DV_W'(i_area) << r_step;
        for (int c = 0; c < 3; c++) begin
            sum[c] = r_job.first ? SUM_W'(r_job.seg[c])
                                 : i_ram_rdata[c*SUM_W +: SUM_W] + SUM_W'(r_job.seg[c]);
            fits[c] = (DV_W'(r_rem[c]) >= dvs);
        end
    end

    assign o_ram_raddr = i_job_head.bcol;
    assign o_ram_waddr = r_job.bcol;
    assign o_ram_wdata = sum;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        o_ram_we  = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = S_ACC;
                end
            end
            S_ACC: begin
                o_ram_we = 1'b1;
                n_state  = r_job.last ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_res_pop) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job_head;
        end
        if (r_state == S_ACC) begin
            r_rem  <= sum;
            r_q    <= '0;
            r_step <= STEP_W'(Q_STEPS - 1);
        end else if (r_state == S_DIV) begin
            for (int c = 0; c < 3; c++) begin
                if (fits[c]) begin
                    r_rem[c]       <= SUM_W'(DV_W'(r_rem[c]) - dvs);
                    r_q[c][r_step] <= 1'b1;
                end
            end
            r_step <= r_step - 1'b1;
        end
        if (out_load) begin
            r_out.avg  <= r_q;
            r_out.bcol <= r_job.bcol;
            r_out.brow <= r_job.brow;
            r_out.done <= r_job.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !$isunknown(r_rem)) |->
        ((SUM_W+BS_W)'(r_rem[0]) < ((SUM_W+BS_W)'(i_area) << ((STEP_W+1)'(r_step) + 1'b1))))
        else $error("divider remainder out of range");
    a_run_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && !r_job.last) |=> (r_state == S_IDLE))
        else $error("non-final run entered divide");
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !out_load) |=> (r_out_valid && r_state == S_OUT))
        else $error("result lost while waiting");

endmodule

// File: hdl/block_average_pixelate_top.sv
// ----------------------------------------------------------------------------
// block_average_pixelate_top
// Mosaic block averager over a raster RGB stream.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// pixel     in         push / full        i_red_in i_green_in i_blue_in i_frame_start
// result    out        empty / pop        o_avg_* o_block_col o_block_row o_frame_done
// config    in         i_cfg_we           i_cfg_idx i_cfg_data
//
// A pixel is taken each cycle while the four-entry job queue has room.
// Each block run of block_size pixels costs the back end a sum RAM read, an
// accumulate and a write back; on the bottom line of a block row it also
// costs 8 restoring divide steps and the result load, so on that line the
// job queue can fill and hold off pixel input.
// Reset is synchronous; the sum RAM needs no clearing, the first line of each
// block overwrites its entry. A held result stalls the back end, then the queue.
// ----------------------------------------------------------------------------
module block_average_pixelate_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bap_pkg::PIX_W-1:0]     i_red_in,
    input  logic [bap_pkg::PIX_W-1:0]     i_green_in,
    input  logic [bap_pkg::PIX_W-1:0]     i_blue_in,
    input  logic                          i_frame_start,
    output logic                          empty,
    input  logic                          pop,
    output logic [bap_pkg::PIX_W-1:0]     o_avg_red,
    output logic [bap_pkg::PIX_W-1:0]     o_avg_green,
    output logic [bap_pkg::PIX_W-1:0]     o_avg_blue,
    output logic [bap_pkg::COL_W-1:0]     o_block_col,
    output logic [bap_pkg::COL_W-1:0]     o_block_row,
    output logic                          o_frame_done,
    input  logic                          i_cfg_we,
    input  logic [bap_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bap_pkg::CFG_W-1:0]     i_cfg_data
);
    import bap_pkg::*;

    t_cfg              r_cfg;
    logic [AREA_W-1:0] r_area;
    logic [2*BS_W-1:0] bs_sq;
    logic [BS_W-1:0]   cfg_bs;
    logic [DIM_W-1:0]  cfg_dim;
    logic              restart;
    logic              accept;

    t_job              front_job, head_job;
    logic              front_push, q_full, q_empty, q_pop;

    logic              ram_we;
    logic [COL_W-1:0]  ram_waddr, ram_raddr;
    logic [3*SUM_W-1:0] ram_wdata, ram_rdata;

    logic              res_valid;
    t_result           res;

    always_comb begin
        cfg_bs = i_cfg_data[BS_W-1:0];
        if (cfg_bs < BS_MIN) begin
            cfg_bs = BS_MIN;
        end else if (cfg_bs > BS_MAX) begin
            cfg_bs = BS_MAX;
        end
        cfg_dim = DIM_W'(i_cfg_data);
        if (cfg_dim == '0) begin
            cfg_dim = DIM_W'(1);
        end else if (cfg_dim > W_MAX) begin
            cfg_dim = W_MAX;
        end
        restart = i_cfg_we && (i_cfg_idx == REG_BLOCK_SIZE ||
                               i_cfg_idx == REG_IMAGE_WIDTH ||
                               i_cfg_idx == REG_IMAGE_HEIGHT);
        bs_sq  = (2*BS_W)'(r_cfg.block_size) * (2*BS_W)'(r_cfg.block_size);
        accept = push && !q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_size <= BS_RESET;
            r_cfg.width      <= W_RESET;
            r_cfg.height     <= H_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BLOCK_SIZE:   r_cfg.block_size <= cfg_bs;
                REG_IMAGE_WIDTH:  r_cfg.width      <= cfg_dim;
                REG_IMAGE_HEIGHT: r_cfg.height     <= (cfg_dim > H_MAX) ? H_MAX : cfg_dim;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= bs_sq[AREA_W-1:0];
    end

    bap_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_restart     (restart),
        .i_accept      (accept),
        .i_red         (i_red_in),
        .i_green       (i_green_in),
        .i_blue        (i_blue_in),
        .i_frame_start (i_frame_start),
        .o_job_push    (front_push),
        .o_job         (front_job)
    );

    bap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_head  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_area      (r_area),
        .i_job_head  (head_job),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    bap_ram #(
        .WIDTH (3*SUM_W),
        .DEPTH (SUM_DEPTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign full         = q_full;
    assign empty        = !res_valid;
    assign o_avg_red    = res.avg[0];
    assign o_avg_green  = res.avg[1];
    assign o_avg_blue   = res.avg[2];
    assign o_block_col  = res.bcol;
    assign o_block_row  = res.brow;
    assign o_frame_done = res.done;

endmodule

// File: tb/sv/block_average_pixelate_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_average_pixelate_top_test
// Self-checking bench for the mosaic block averager. Raster pixel streams over
// many block and image sizes, including clamped and partial-block cases, are
// pushed under random gaps. An in-bench model of the block sums predicts each
// block average, and each popped result is compared with it.
// ----------------------------------------------------------------------------
module block_average_pixelate_top_test;
    import bap_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;
    typedef enum {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_FLAT, FILL_MIXED} t_fill;

    typedef struct {
        bit [PIX_W-1:0] red, green, blue;
        bit             frame_start;
    } t_pixel;

    typedef struct {
        bit [PIX_W-1:0] red, green, blue;
        bit [COL_W-1:0] col, row;
        bit             done;
    } t_block_avg;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 push          = 1'b0;
    logic                 full;
    logic [PIX_W-1:0]     i_red_in      = '0;
    logic [PIX_W-1:0]     i_green_in    = '0;
    logic [PIX_W-1:0]     i_blue_in     = '0;
    logic                 i_frame_start = 1'b0;
    logic                 empty;
    logic                 pop           = 1'b0;
    logic [PIX_W-1:0]     o_avg_red;
    logic [PIX_W-1:0]     o_avg_green;
    logic [PIX_W-1:0]     o_avg_blue;
    logic [COL_W-1:0]     o_block_col;
    logic [COL_W-1:0]     o_block_row;
    logic                 o_frame_done;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    // mirror of the block state
    bit [BS_W-1:0]  reg_bs = BS_W'(20);
    bit [CFG_W-1:0] reg_w  = CFG_W'(640);
    bit [CFG_W-1:0] reg_h  = CFG_W'(480);
    bit [SUM_W-1:0] col_sums [SUM_DEPTH][3];
    bit [POS_W-1:0] pos_x, pos_y;
    bit [OFS_W-1:0] ofs_x, ofs_y;

    t_pixel      pending_pixels [$];
    t_block_avg  expected_avgs [$];
    t_pixel      pixel_on_port;
    t_block_avg  avg_want;

    int unsigned send_idle_pct  = 0;
    int unsigned pop_stall_pct  = 0;
    int unsigned items_issued   = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned writes_done    = 0;
    int unsigned mismatches     = 0;
    int unsigned stall_cycles   = 0;

    int unsigned gen_pos  = 0;
    t_fill       gen_fill = FILL_RANDOM;
    bit [31:0]   gen_flat = '0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    block_average_pixelate_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_frame_start (i_frame_start),
        .empty         (empty),
        .pop           (pop),
        .o_avg_red     (o_avg_red),
        .o_avg_green   (o_avg_green),
        .o_avg_blue    (o_avg_blue),
        .o_block_col   (o_block_col),
        .o_block_row   (o_block_row),
        .o_frame_done  (o_frame_done),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_raster();
        pos_x = '0;
        pos_y = '0;
        ofs_x = '0;
        ofs_y = '0;
    endfunction

    function automatic void predict_block_average(input t_pixel px);
        int unsigned    bs, w, h, bcol, brow, area;
        bit [PIX_W-1:0] chan [3];
        bit             first;
        t_block_avg     res;
        bs = clamp_to(reg_bs, MIN_BLOCK, MAX_BLOCK);
        w  = clamp_to(reg_w, 1, MAX_WIDTH);
        h  = clamp_to(reg_h, 1, HEIGHT_LIMIT);
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        if (px.frame_start)
            restart_raster();
        bcol = pos_x / bs;
        brow = pos_y / bs;
        if (bcol < w / bs && brow < h / bs && bcol < SUM_DEPTH) begin
            first = (ofs_x == 0 && ofs_y == 0);
            for (int c = 0; c < 3; c++)
                col_sums[bcol][c] = first ? SUM_W'(chan[c]) : col_sums[bcol][c] + chan[c];
            if (ofs_x == bs - 1 && ofs_y == bs - 1) begin
                area      = bs * bs;
                res.red   = PIX_W'(col_sums[bcol][0] / area);
                res.green = PIX_W'(col_sums[bcol][1] / area);
                res.blue  = PIX_W'(col_sums[bcol][2] / area);
                res.col   = COL_W'(bcol);
                res.row   = COL_W'(brow);
                res.done  = (bcol == w / bs - 1 && brow == h / bs - 1);
                expected_avgs.push_back(res);
            end
        end
        if (int'(ofs_x) + 1 >= bs) ofs_x = '0;
        else ofs_x++;
        if (int'(pos_x) + 1 >= w) begin
            pos_x = '0;
            ofs_x = '0;
            if (int'(ofs_y) + 1 >= bs) ofs_y = '0;
            else ofs_y++;
            if (int'(pos_y) + 1 >= h) begin
                pos_y = '0;
                ofs_y = '0;
            end else begin
                pos_y++;
            end
        end else begin
            pos_x++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_BLOCK_SIZE:   reg_bs = data[BS_W-1:0];
            REG_IMAGE_WIDTH:  reg_w  = data;
            REG_IMAGE_HEIGHT: reg_h  = data;
            default: ;
        endcase
        restart_raster();
        gen_pos = 0;
        writes_done++;
    endtask

    // raster frames, mostly opened by frame_start, some wrapping, a few cut short
    task automatic queue_pixels(input int unsigned count, input t_fill fill);
        int unsigned frame_len;
        t_pixel      px;
        frame_len = clamp_to(reg_w, 1, MAX_WIDTH) * clamp_to(reg_h, 1, HEIGHT_LIMIT);
        repeat (count) begin
            if (gen_pos == 0)
                px.frame_start = ($urandom_range(3) != 0);
            else
                px.frame_start = (frame_len <= 1024 && $urandom_range(frame_len * 4) == 0);
            if (px.frame_start)
                gen_pos = 0;
            if (gen_pos == 0) begin
                gen_fill = (fill == FILL_MIXED) ? t_fill'($urandom_range(FILL_FLAT)) : fill;
                gen_flat = $urandom;
            end
            case (gen_fill)
                FILL_MAX:  {px.red, px.green, px.blue} = '1;
                FILL_ZERO: {px.red, px.green, px.blue} = '0;
                FILL_FLAT: {px.red, px.green, px.blue} = gen_flat[23:0];
                default:   {px.red, px.green, px.blue} = 24'($urandom);
            endcase
            pending_pixels.push_back(px);
            items_issued++;
            gen_pos = (gen_pos + 1) % frame_len;
        end
    endtask

    task automatic wait_results_drained();
        while (items_accepted != items_issued || expected_avgs.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic settle();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input t_idle mode);
        case (mode)
            IDLE_SEND: begin send_idle_pct = 82; pop_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  pop_stall_pct = 82; end
            IDLE_BOTH: begin send_idle_pct = 32; pop_stall_pct = 32; end
            default:   begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        endcase
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] bs, input logic [CFG_W-1:0] w,
                             input logic [CFG_W-1:0] h, input int unsigned count,
                             input t_idle idle, input t_fill fill, input bit hold_midway);
        settle();
        write_reg(REG_BLOCK_SIZE, bs);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        set_idle(idle);
        if (hold_midway) begin
            queue_pixels(count / 2, fill);
            wait_results_drained();
            queue_pixels(count - count / 2, fill);
        end else begin
            queue_pixels(count, fill);
        end
    endtask

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_block_average(pixel_on_port);
                items_accepted++;
            end
            if (push && full) begin
                // hold the transaction
            end else if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                pixel_on_port = pending_pixels.pop_front();
                push          <= 1'b1;
                i_red_in      <= pixel_on_port.red;
                i_green_in    <= pixel_on_port.green;
                i_blue_in     <= pixel_on_port.blue;
                i_frame_start <= pixel_on_port.frame_start;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (expected_avgs.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected block result: rgb %0d/%0d/%0d col %0d row %0d done %0b",
                                 o_avg_red, o_avg_green, o_avg_blue, o_block_col,
                                 o_block_row, o_frame_done);
                    mismatches++;
                end else begin
                    avg_want = expected_avgs.pop_front();
                    if (o_avg_red !== avg_want.red || o_avg_green !== avg_want.green ||
                        o_avg_blue !== avg_want.blue || o_block_col !== avg_want.col ||
                        o_block_row !== avg_want.row || o_frame_done !== avg_want.done) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("result %0d expected rgb %0d/%0d/%0d col %0d row %0d done %0b",
                                     results_seen, avg_want.red, avg_want.green, avg_want.blue,
                                     avg_want.col, avg_want.row, avg_want.done);
                            $display("result %0d actual   rgb %0d/%0d/%0d col %0d row %0d done %0b",
                                     results_seen, o_avg_red, o_avg_green, o_avg_blue,
                                     o_block_col, o_block_row, o_frame_done);
                        end
                        mismatches++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || i_cfg_we)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("block_average_pixelate_top_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: too few pixels to finish a block
        set_idle(IDLE_NONE);
        queue_pixels(4, FILL_RANDOM);
        // single-block image: saturated frame, then a dark one
        run_phase(4, 4, 4, 16, IDLE_NONE, FILL_MAX, 1'b0);
        queue_pixels(16, FILL_ZERO);
        // clamped low: one-pixel image under a 4-pixel block
        run_phase(0, 0, 0, 6, IDLE_NONE, FILL_RANDOM, 1'b0);
        // clamped high
        run_phase(127, 4095, 4095, 6, IDLE_NONE, FILL_RANDOM, 1'b0);

        run_phase(4, 13, 9, 200, IDLE_NONE, FILL_MIXED, 1'b0);
        run_phase(5, 10, 10, 200, IDLE_SEND, FILL_MIXED, 1'b0);
        run_phase(4, 8, 8, 200, IDLE_RECV, FILL_MIXED, 1'b1);
        run_phase(6, 20, 13, 200, IDLE_BOTH, FILL_MIXED, 1'b0);
        // only the low 7 bits of the size field count: size 7
        run_phase(12'h087, 15, 22, 220, IDLE_SEND, FILL_MIXED, 1'b0);
        run_phase(3, 12, 12, 150, IDLE_RECV, FILL_MIXED, 1'b0);
        run_phase(9, 31, 19, 300, IDLE_NONE, FILL_MIXED, 1'b0);
        // one 16 by 16 block
        run_phase(16, 16, 16, 256, IDLE_RECV, FILL_FLAT, 1'b0);

        settle();
        if (expected_avgs.size() != 0)
            mismatches += expected_avgs.size();
        $display("covered %0d pixels and %0d block averages across %0d register writes",
                 items_accepted, results_seen, writes_done);
        $display("whole blocks of 4..16, clamped sizes up to 64 and 2048, partial blocks, wraps");
        if (mismatches == 0)
            $display("block_average_pixelate_top_test OK");
        else
            $display("block_average_pixelate_top_test NOT OK");
        $finish;
    end

endmodule

// File: files.f
hdl/bap_pkg.sv
hdl/bap_ram.sv
hdl/bap_fifo.sv
hdl/bap_front.sv
hdl/bap_back.sv
hdl/block_average_pixelate_top.sv
tb/sv/block_average_pixelate_top_test.sv
